@@ rtl/hvt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the homogeneous vertex transform unit.
// No dependencies; imported by hvt_row_dot and homogeneous_vertex_transform_unit.

package hvt_pkg;

  // fixed-point format and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;

  // configuration register file
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 2 * COEF_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_COLS01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_COLS23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_COLS01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_COLS23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_COLS01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_COLS23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3_COLS01 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3_COLS23 = 3'd7;

  // 1.0 in the low and in the high coefficient of a register
  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (COEF_W + FRAC_BITS);

  typedef struct packed {
    logic signed [COEF_W-1:0] in_x;
    logic signed [COEF_W-1:0] in_y;
    logic signed [COEF_W-1:0] in_z;
    logic signed [COEF_W-1:0] in_w;
  } in_data_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] out_x;
    logic signed [COEF_W-1:0] out_y;
    logic signed [COEF_W-1:0] out_z;
    logic signed [COEF_W-1:0] out_w;
    logic                     clipped;
  } out_data_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic out_en;
  } pipe_en_t;

  // identity matrix after reset
  function automatic logic [CFG_W-1:0] cfg_reset_value(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_W-1:0] val;
    case (idx)
      CFG_ROW0_COLS01: val = ONE_LO;
      CFG_ROW1_COLS01: val = ONE_HI;
      CFG_ROW2_COLS23: val = ONE_LO;
      CFG_ROW3_COLS23: val = ONE_HI;
      default:         val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/hvt_row_dot.sv @@
`timescale 1ns / 1ps
// One matrix row dotted with the input vector: multiply, pair add, final add/shift/saturate.
// Depends on hvt_pkg; pipeline enables come from the top level.

module hvt_row_dot
  import hvt_pkg::*;
(
  input  logic                     clk,
  input  pipe_en_t                 en,
  input  in_data_t                 vec,
  input  logic [CFG_W-1:0]         coef01,
  input  logic [CFG_W-1:0]         coef23,
  output logic signed [COEF_W-1:0] result,
  output logic                     clip
);

  logic signed [COEF_W-1:0] coef [4];
  logic signed [COEF_W-1:0] comp [4];
  logic signed [PROD_W-1:0] prod_nxt [4];
  logic signed [PROD_W-1:0] prod_r [4];
  logic signed [PAIR_W-1:0] pair_nxt [2];
  logic signed [PAIR_W-1:0] pair_r [2];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic                     all_zero;
  logic                     all_one;
  logic signed [COEF_W-1:0] res_nxt;
  logic                     clip_nxt;
  logic signed [COEF_W-1:0] res_r;
  logic                     clip_r;

  // unpack coefficients and vector components
  assign coef[0] = coef01[COEF_W-1:0];
  assign coef[1] = coef01[CFG_W-1:COEF_W];
  assign coef[2] = coef23[COEF_W-1:0];
  assign coef[3] = coef23[CFG_W-1:COEF_W];
  assign comp[0] = vec.in_x;
  assign comp[1] = vec.in_y;
  assign comp[2] = vec.in_z;
  assign comp[3] = vec.in_w;

  // exact signed 32x32 products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = PROD_W'(coef[i]) * PROD_W'(comp[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
  end

  // pairwise sums, one bit of growth
  assign pair_nxt[0] = {prod_r[0][PROD_W-1], prod_r[0]} + {prod_r[1][PROD_W-1], prod_r[1]};
  assign pair_nxt[1] = {prod_r[2][PROD_W-1], prod_r[2]} + {prod_r[3][PROD_W-1], prod_r[3]};

  always_ff @(posedge clk) begin
    if (en.add_en) begin
      pair_r[0] <= pair_nxt[0];
      pair_r[1] <= pair_nxt[1];
    end
  end

  // full sum, floor shift, saturate to 32 bits
  assign sum      = {pair_r[0][PAIR_W-1], pair_r[0]} + {pair_r[1][PAIR_W-1], pair_r[1]};
  assign shifted  = sum >>> FRAC_BITS;
  assign all_zero = ~|shifted[SUM_W-1:COEF_W-1];
  assign all_one  = &shifted[SUM_W-1:COEF_W-1];

  always_comb begin
    clip_nxt = 1'b0;
    res_nxt  = shifted[COEF_W-1:0];
    if (!all_zero && !all_one) begin
      clip_nxt = 1'b1;
      if (shifted[SUM_W-1]) begin
        res_nxt = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
        res_nxt = {1'b0, {(COEF_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.out_en) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign result = res_r;
  assign clip   = clip_r;

endmodule

@@ rtl/homogeneous_vertex_transform_unit.sv @@
`timescale 1ns / 1ps
// Top level: 4x4 Q16.16 matrix times 4-vector, four-stage pipeline.
// Depends on hvt_pkg and hvt_row_dot (one instance per matrix row).
//
//   channel  ports                          direction  moves
//   input    in_valid, in_stall, in_data    in         one vector per transfer
//   result   out_valid, out_stall, out_data out        transformed vector + clip flag
//   config   cfg_we, cfg_index, cfg_data    in         one 64-bit register write
//
// One vertex per clock sustained while out_stall is low; four register stages (input register,
// multiply, pair add, final add/shift/saturate) lie between the input transfer and out_valid.
// Synchronous active-low reset clears all valid bits and loads the identity matrix.
// out_stall holds the last stage; bubbles upstream still fill, then in_stall rises.

module homogeneous_vertex_transform_unit
  import hvt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_data_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_data_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] cfg_r [NUM_CFG];
  in_data_t         vec_r;
  logic             vld1_r, vld2_r, vld3_r, vld4_r;
  logic             rdy1, rdy2, rdy3, rdy4;
  pipe_en_t         en;
  logic signed [COEF_W-1:0] row_res [4];
  logic             row_clip [4];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_r[i] <= cfg_reset_value(CFG_IDX_W'(i));
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // a stage can load when empty or when its contents move on
  assign rdy4 = !vld4_r || !out_stall;
  assign rdy3 = !vld3_r || rdy4;
  assign rdy2 = !vld2_r || rdy3;
  assign rdy1 = !vld1_r || rdy2;

  assign in_stall  = !rdy1;
  assign en.mul_en = rdy2 && vld1_r;
  assign en.add_en = rdy3 && vld2_r;
  assign en.out_en = rdy4 && vld3_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= in_valid;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
      if (rdy4) vld4_r <= vld3_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      vec_r <= in_data;
    end
  end

  // one datapath per matrix row
  for (genvar r = 0; r < 4; r++) begin : g_row
    hvt_row_dot u_row (
      .clk    (clk),
      .en     (en),
      .vec    (vec_r),
      .coef01 (cfg_r[2*r]),
      .coef23 (cfg_r[2*r+1]),
      .result (row_res[r]),
      .clip   (row_clip[r])
    );
  end

  // result assembly
  assign out_valid        = vld4_r;
  assign out_data.out_x   = row_res[0];
  assign out_data.out_y   = row_res[1];
  assign out_data.out_z   = row_res[2];
  assign out_data.out_w   = row_res[3];
  assign out_data.clipped = row_clip[0] | row_clip[1] | row_clip[2] | row_clip[3];

endmodule

@@ verif/homogeneous_vertex_transform_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for homogeneous_vertex_transform_unit: Q16.16 4x4 matrix times vertex.
// Depends on hvt_pkg and the rtl top level; predicts each transform with exact 68-bit sums.

module homogeneous_vertex_transform_unit_test;
  import hvt_pkg::*;

  typedef logic [CFG_W-1:0] matrix_t [NUM_CFG];

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     DRAIN_CYCLES   = 8;
  localparam int     PHASE_VERTICES = 150;
  localparam longint SAT_HI         = 64'sh7FFF_FFFF;
  localparam longint SAT_LO         = -64'sd2147483648;
  localparam logic [COEF_W-1:0] FIX_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] FIX_MIN = 32'h8000_0000;
  localparam logic [COEF_W-1:0] FIX_ONE = 32'h0001_0000;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_data_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_data_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  matrix_t   matrix_regs;
  out_data_t queued_transforms [$];
  int        mismatch_count = 0;
  int        burst_left     = 0;
  int        idle_cycles    = 0;
  int        stall_mode     = 0;
  int        stall_left     = 0;

  homogeneous_vertex_transform_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // row r dot vertex, exact sum, floor shift, saturate
  function automatic out_data_t transform_vertex(input in_data_t v);
    logic signed [COEF_W-1:0]  comp [4];
    logic signed [COEF_W-1:0]  coef;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W+1:0]   acc;
    logic        [COEF_W-1:0]  row_out [4];
    logic                      clip;
    out_data_t                 res;
    comp[0] = v.in_x;
    comp[1] = v.in_y;
    comp[2] = v.in_z;
    comp[3] = v.in_w;
    clip = 1'b0;
    for (int row = 0; row < 4; row++) begin
      acc = '0;
      for (int col = 0; col < 4; col++) begin
        coef = matrix_regs[2 * row + col / 2][(col % 2) * COEF_W +: COEF_W];
        prod = coef * comp[col];
        acc  = acc + prod;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > SAT_HI) begin
        row_out[row] = FIX_MAX;
        clip = 1'b1;
      end else if (acc < SAT_LO) begin
        row_out[row] = FIX_MIN;
        clip = 1'b1;
      end else begin
        row_out[row] = acc[COEF_W-1:0];
      end
    end
    res.out_x   = row_out[0];
    res.out_y   = row_out[1];
    res.out_z   = row_out[2];
    res.out_w   = row_out[3];
    res.clipped = clip;
    return res;
  endfunction

  // random fixed-point value of a given flavor
  function automatic logic [COEF_W-1:0] rand_fixed(input int kind);
    logic [COEF_W-1:0] v;
    case (kind)
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: begin
        case ($urandom_range(0, 5))
          0:       v = FIX_MAX;
          1:       v = FIX_MIN;
          2:       v = '0;
          3:       v = '1;
          4:       v = FIX_ONE;
          default: v = -FIX_ONE;
        endcase
      end
      default: begin
        v = $urandom;
        v = $signed(v) >>> $urandom_range(0, 31);
      end
    endcase
    return v;
  endfunction

  function automatic in_data_t rand_vertex();
    in_data_t v;
    v.in_x = rand_fixed($urandom_range(0, 3));
    v.in_y = rand_fixed($urandom_range(0, 3));
    v.in_z = rand_fixed($urandom_range(0, 3));
    v.in_w = rand_fixed($urandom_range(0, 3));
    return v;
  endfunction

  function automatic matrix_t identity_matrix();
    matrix_t m;
    foreach (m[i]) m[i] = '0;
    m[CFG_ROW0_COLS01] = ONE_LO;
    m[CFG_ROW1_COLS01] = ONE_HI;
    m[CFG_ROW2_COLS23] = ONE_LO;
    m[CFG_ROW3_COLS23] = ONE_HI;
    return m;
  endfunction

  function automatic matrix_t uniform_matrix(input logic [COEF_W-1:0] c);
    matrix_t m;
    foreach (m[i]) m[i] = {c, c};
    return m;
  endfunction

  // one vertex transfer, then burst/gap pacing
  task automatic send_vertex(input in_data_t v);
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
    queued_transforms.push_back(transform_vertex(v));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_components(input logic [COEF_W-1:0] x, y, z, w);
    in_data_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    send_vertex(v);
  endtask

  // stop sending and let the pipeline empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (queued_transforms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all eight coefficient registers back to back
  task automatic load_matrix(input matrix_t m);
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= m[i];
      @(posedge clk);
      matrix_regs[i] = m[i];
    end
    cfg_we <= 1'b0;
  endtask

  // reset matrix passes vertices through unchanged
  task automatic check_identity_reset();
    send_components(FIX_MAX, FIX_MIN, '0, '1);
    send_components(32'h0000_0001, '1, FIX_MAX, FIX_MIN);
    send_components('0, '0, '0, '0);
    send_components(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // clipping high and low, one clipped row, 66-bit sum
  task automatic check_saturation();
    matrix_t m;
    wait_drained();
    load_matrix(uniform_matrix(FIX_MAX));
    send_components(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
    send_components(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
    send_components(32'h0000_0001, '0, '0, '0);
    wait_drained();
    load_matrix(uniform_matrix(FIX_MIN));
    send_components(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
    send_components(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
    wait_drained();
    m = identity_matrix();
    m[CFG_ROW3_COLS23] = {FIX_MAX, FIX_MAX};
    load_matrix(m);
    send_components(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, FIX_MAX);
    send_components(FIX_MIN, FIX_MAX, '1, '0);
  endtask

  // arithmetic shift rounds toward minus infinity
  task automatic check_floor_rounding();
    wait_drained();
    load_matrix(uniform_matrix('1));
    send_components(32'h0000_0001, '0, '0, '0);
    send_components(32'h0001_0000, '0, '0, '0);
    send_components(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_components('1, '0, '0, '0);
    wait_drained();
    load_matrix(uniform_matrix('0));
    send_components(FIX_MAX, FIX_MIN, 32'h1234_5678, '1);
  endtask

  // random matrices of several flavors, random vertices
  task automatic check_random_transforms();
    matrix_t m;
    logic [COEF_W-1:0] lo, hi;
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      foreach (m[i]) begin
        lo   = rand_fixed(phase < 4 ? phase : $urandom_range(0, 3));
        hi   = rand_fixed(phase < 4 ? phase : $urandom_range(0, 3));
        m[i] = {hi, lo};
      end
      load_matrix(m);
      repeat (PHASE_VERTICES) send_vertex(rand_vertex());
    end
  endtask

  // receiver stall pattern: free, light, heavy, solid
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 20) : $urandom_range(1, 40);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 30);
      2:       out_stall <= ($urandom_range(0, 99) < 80);
      default: out_stall <= 1'b1;
    endcase
  end

  task automatic check_component(input string name, input logic [COEF_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  // result checking
  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (queued_transforms.size() == 0) begin
        $error("result transfer with no vertex outstanding: %h", out_data);
        mismatch_count++;
      end else begin
        want = queued_transforms.pop_front();
        check_component("out_x", want.out_x, out_data.out_x);
        check_component("out_y", want.out_y, out_data.out_y);
        check_component("out_z", want.out_z, out_data.out_z);
        check_component("out_w", want.out_w, out_data.out_w);
        check_component("clipped", COEF_W'(want.clipped), COEF_W'(out_data.clipped));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("homogeneous_vertex_transform_unit_test: FAIL");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    matrix_regs = identity_matrix();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_identity_reset();
    check_saturation();
    check_floor_rounding();
    check_random_transforms();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("homogeneous_vertex_transform_unit_test: PASS");
    end else begin
      $display("homogeneous_vertex_transform_unit_test: FAIL");
    end
    $finish;
  end

endmodule
